@@ rtl/tdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsc_pkg: shared types and functions for the triangular double-to-single converter
// Holds the binary64 to binary32 rounding function and the overflow test.
// ----------------------------------------------------------------------------
package tdsc_pkg;

    localparam int MAX_DIM  = 1024;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int IDX_W    = 10;
    localparam int OFS_W    = 20;
    localparam int CFG_W    = 11;
    localparam int NUM_LANE = 2;

    localparam logic [63:0] FLT_MAX_AS_DOUBLE = 64'h47EF_FFFF_E000_0000;
    localparam logic [63:0] DOUBLE_INF_ABS    = 64'h7FF0_0000_0000_0000;

    localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;
    localparam logic [1:0] REG_UPPER_MODE  = 2'd1;
    localparam logic [1:0] REG_DEST_STRIDE = 2'd2;

    typedef struct packed {
        logic [31:0] bits;
        logic        over;
    } t_lane_res;

    // Round one binary64 word to binary32, nearest even.
    function automatic logic [31:0] to_single(input logic [63:0] b);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] man;
        logic [53:0] m;
        logic [53:0] q;
        logic [53:0] rem;
        logic [53:0] half;
        logic [5:0]  sh;
        logic [31:0] base;
        logic [31:0] res;
        sgn  = b[63];
        ex   = b[62:52];
        man  = b[51:0];
        m    = {2'b01, man};
        sh   = 6'd29;
        base = '0;
        res  = {sgn, 31'd0};
        if (ex == 11'h7FF) begin
            if (man != '0) res = {sgn, 8'hFF, 1'b1, man[50:29]};
            else           res = {sgn, 8'hFF, 23'd0};
        end else if (ex == 11'd0) begin
            res = {sgn, 31'd0};
        end else if (ex >= 11'd1151) begin
            res = {sgn, 8'hFF, 23'd0};
        end else if (ex >= 11'd897 || (11'd926 - ex) < 11'd54) begin
            if (ex >= 11'd897) begin
                sh   = 6'd29;
                base = {1'b0, 8'(ex - 11'd897), 23'd0};
            end else begin
                sh   = 6'(11'd926 - ex);
                base = '0;
            end
            q    = m >> sh;
            half = 54'd1 << (sh - 6'd1);
            rem  = m & ((54'd1 << sh) - 54'd1);
            if (rem > half || (rem == half && q[0])) q = q + 54'd1;
            res = {sgn, 31'd0} | (base + q[31:0]);
        end
        return res;
    endfunction

    function automatic logic too_big(input logic [63:0] b);
        logic [63:0] a;
        a = {1'b0, b[62:0]};
        return (a > FLT_MAX_AS_DOUBLE) && (a <= DOUBLE_INF_ABS);
    endfunction

endpackage

@@ rtl/tdsc_lane.sv @@
// ----------------------------------------------------------------------------
// tdsc_lane: one conversion lane
// Rounds one part to binary32 and flags a magnitude beyond single range.
// ----------------------------------------------------------------------------
module tdsc_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [63:0]          i_bits,
    output tdsc_pkg::t_lane_res  o_res
);
    import tdsc_pkg::*;

    t_lane_res r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.bits <= to_single(i_bits);
            r_res.over <= too_big(i_bits);
        end
    end

    assign o_res = r_res;
endmodule

@@ rtl/tdsc_walk.sv @@
// ----------------------------------------------------------------------------
// tdsc_walk: triangle walker and merge stage
// Counts row, column and offset, merges lane overflow into the sticky flag.
// ----------------------------------------------------------------------------
module tdsc_walk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_first,
    input  logic [tdsc_pkg::CFG_W-1:0] i_size,
    input  logic                      i_upper,
    input  logic [tdsc_pkg::CFG_W-1:0] i_stride,
    input  tdsc_pkg::t_lane_res       i_re,
    input  tdsc_pkg::t_lane_res       i_im,
    output logic [tdsc_pkg::IDX_W-1:0] o_row,
    output logic [tdsc_pkg::IDX_W-1:0] o_col,
    output logic [tdsc_pkg::OFS_W-1:0] o_ofs,
    output logic                      o_store,
    output logic                      o_over,
    output logic                      o_last
);
    import tdsc_pkg::*;

    // Counters are one bit wider than the index so n-1 compares work at MAX_DIM.
    logic [DIM_W-1:0] r_row, r_col, n_row, n_col, c_row, c_col;
    logic [OFS_W-1:0] r_base, n_base, c_base;
    logic             r_abort, n_abort, c_abort;
    logic [DIM_W-1:0] w_n, w_nm1;
    logic             w_over, w_col_end, w_last;

    assign w_n    = (i_size > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(i_size);
    assign w_nm1  = w_n - DIM_W'(1);
    assign w_over = i_re.over | i_im.over;

    always_comb begin
        c_row   = i_first ? '0 : r_row;
        c_col   = i_first ? '0 : r_col;
        c_base  = i_first ? '0 : r_base;
        c_abort = i_first ? 1'b0 : r_abort;
        w_col_end = i_upper ? (c_row >= c_col) : (c_row >= w_nm1);
        w_last    = w_col_end && (c_col >= w_nm1);
        n_row = c_row; n_col = c_col; n_base = c_base; n_abort = c_abort;
        o_row = '0; o_col = '0; o_ofs = '0; o_store = 1'b0; o_last = 1'b0;
        o_over = c_abort;
        if (w_n != '0) begin
            n_abort = c_abort | w_over;
            o_row   = c_row[IDX_W-1:0];
            o_col   = c_col[IDX_W-1:0];
            o_ofs   = OFS_W'(c_row) + c_base;
            o_store = ~n_abort;
            o_over  = n_abort;
            o_last  = w_last;
            if (w_last) begin
                n_row = '0; n_col = '0; n_base = '0;
            end else if (w_col_end) begin
                n_col  = c_col + DIM_W'(1);
                n_row  = i_upper ? '0 : c_col + DIM_W'(1);
                n_base = c_base + OFS_W'(i_stride);
            end else begin
                n_row = c_row + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0; r_col <= '0; r_base <= '0; r_abort <= 1'b0;
        end else if (i_en) begin
            r_row <= n_row; r_col <= n_col; r_base <= n_base; r_abort <= n_abort;
        end
    end
endmodule

@@ rtl/triangular_double_to_single_convert.sv @@
// ----------------------------------------------------------------------------
// triangular_double_to_single_convert: triangle walker with binary64 to binary32 rounding
// Converts complex matrix elements and tags them with position and store enable.
// ----------------------------------------------------------------------------
// One element per cycle: an accepted transaction is converted by two lanes (real and
// imaginary) into a one-entry register stage, and the walker counts the triangle
// when that stage hands its transaction on. A stalled output holds the stage and the
// next input waits. The first overflowing part clears store enable for the rest of
// the matrix until the next first_of_matrix transaction.
module triangular_double_to_single_convert (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // real_bits, imag_bits
    input  logic         s_axis_tuser,  // first_of_matrix
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // single_real, single_imag, row, col, offset,
                                        // store_enable, overflow_flag, zero pad
    output logic         m_axis_tlast,  // last_of_matrix
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tdsc_pkg::*;

    logic             r_vld, r_first;
    logic [CFG_W-1:0] r_size, r_stride;
    logic             r_upper;
    logic             w_take, w_give;
    t_lane_res        w_re, w_im;
    logic [IDX_W-1:0] w_row, w_col;
    logic [OFS_W-1:0] w_ofs;
    logic             w_store, w_over, w_last;

    // Accept when the stage is empty or is being drained this cycle.
    assign w_give        = r_vld & m_axis_tready;
    assign s_axis_tready = ~r_vld | m_axis_tready;
    assign w_take        = s_axis_tvalid & s_axis_tready;
    assign pready        = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0; r_size <= '0; r_upper <= 1'b1; r_stride <= CFG_W'(1);
        end else begin
            if (s_axis_tready) r_vld <= s_axis_tvalid;
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_MATRIX_SIZE: r_size   <= pwdata[CFG_W-1:0];
                    REG_UPPER_MODE:  r_upper  <= pwdata[0];
                    REG_DEST_STRIDE: r_stride <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_first <= s_axis_tuser;
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MATRIX_SIZE: prdata = 32'(r_size);
            REG_UPPER_MODE:  prdata = 32'(r_upper);
            REG_DEST_STRIDE: prdata = 32'(r_stride);
            default:         prdata = '0;
        endcase
    end

    tdsc_lane u_re (.i_clk(i_clk), .i_en(w_take), .i_bits(s_axis_tdata[63:0]),   .o_res(w_re));
    tdsc_lane u_im (.i_clk(i_clk), .i_en(w_take), .i_bits(s_axis_tdata[127:64]), .o_res(w_im));

    // Walker advances on output hand-off; its fields are combinational from the stage.
    tdsc_walk u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_give), .i_first(r_first),
        .i_size(r_size), .i_upper(r_upper), .i_stride(r_stride),
        .i_re(w_re), .i_im(w_im),
        .o_row(w_row), .o_col(w_col), .o_ofs(w_ofs),
        .o_store(w_store), .o_over(w_over), .o_last(w_last)
    );

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {6'd0, w_over, w_store, w_ofs, w_col, w_row, w_im.bits, w_re.bits};
    assign m_axis_tlast  = w_last;

    a_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(w_store && w_over)) else $error("store with overflow");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |-> s_axis_tready) else $error("empty stage not ready");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("lost item");
endmodule

@@ tb/tb_triangular_double_to_single_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangular_double_to_single_convert: stream test of the triangle converter
// Drives complex binary64 elements through the block under several register
// settings, predicts every binary32 word and triangle position in the bench,
// and compares each output transaction field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_triangular_double_to_single_convert;
    import tdsc_pkg::*;

    typedef struct packed {
        logic [31:0] sre;
        logic [31:0] sim;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [19:0] ofs;
        logic        st_en;
        logic        ovf;
        logic        last;
    } t_elem_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;  // real_bits, imag_bits
    logic         s_axis_tuser;  // first_of_matrix
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;  // single_real, single_imag, row, col, offset,
                                 // store_enable, overflow_flag, zero pad
    logic         m_axis_tlast;  // last_of_matrix
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    triangular_double_to_single_convert dut (.*);

    // Bench copy of registers and walker state.
    logic [10:0] cfg_size;
    logic        cfg_upper;
    logic [10:0] cfg_stride;
    logic [9:0]  walk_row;
    logic [9:0]  walk_col;
    logic [19:0] walk_base;
    logic        walk_abort;

    t_elem_res   expected_q[$];
    int          err_count;
    int          res_count;
    int          idle_cycles;
    bit          rx_gaps;
    bit          rx_hold;
    bit          tx_gaps;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Binary64 to binary32, nearest even, written out on the raw fields.
    function automatic logic [31:0] round_to_single(input logic [63:0] b);
        logic [31:0]  sgn;
        logic [10:0]  ex;
        logic [52:0]  m;
        logic [63:0]  q;
        logic [63:0]  rem;
        logic [63:0]  half;
        int           sh;
        logic [31:0]  base;
        sgn = {b[63], 31'd0};
        ex  = b[62:52];
        m   = {1'b1, b[51:0]};
        if (ex == 11'h7FF)
            return (b[51:0] != 0) ? (sgn | 32'h7FC0_0000 | 32'(b[51:29]))
                                  : (sgn | 32'h7F80_0000);
        if (ex == 0) return sgn;
        if (ex >= 11'd1151) return sgn | 32'h7F80_0000;
        if (ex >= 11'd897) begin
            sh   = 29;
            base = 32'(ex - 11'd897) << 23;
        end else begin
            sh   = 926 - int'(ex);
            base = 0;
            if (sh >= 54) return sgn;
        end
        q    = 64'(m) >> sh;
        rem  = 64'(m) & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        return sgn | (base + q[31:0]);
    endfunction

    function automatic bit beyond_flt_max(input logic [63:0] b);
        logic [63:0] a;
        a = {1'b0, b[62:0]};
        return a > 64'h47EF_FFFF_E000_0000 && a <= 64'h7FF0_0000_0000_0000;
    endfunction

    // Advance the triangle walker for one element and queue its result.
    function automatic void predict_element(input logic [63:0] re, input logic [63:0] im,
                                            input logic first);
        t_elem_res r;
        int        n;
        bit        col_end;
        bit        last;
        n     = (cfg_size > MAX_DIM) ? MAX_DIM : cfg_size;
        r     = '0;
        r.sre = round_to_single(re);
        r.sim = round_to_single(im);
        if (first) begin
            walk_row = 0; walk_col = 0; walk_base = 0; walk_abort = 0;
        end
        if (n == 0) begin
            r.ovf = walk_abort;
            expected_q.push_back(r);
            return;
        end
        if (beyond_flt_max(re) || beyond_flt_max(im)) walk_abort = 1;
        col_end = cfg_upper ? (walk_row >= walk_col) : (int'(walk_row) >= n - 1);
        last    = col_end && int'(walk_col) >= n - 1;
        r.row   = walk_row;
        r.col   = walk_col;
        r.ofs   = 20'(walk_row) + walk_base;
        r.st_en = ~walk_abort;
        r.ovf   = walk_abort;
        r.last  = last;
        expected_q.push_back(r);
        if (last) begin
            walk_row = 0; walk_col = 0; walk_base = 0;
        end else if (col_end) begin
            walk_col  = walk_col + 1;
            walk_row  = cfg_upper ? 10'd0 : walk_col;
            walk_base = walk_base + 20'(cfg_stride);
        end else begin
            walk_row = walk_row + 1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", res_count, what, got, want);
        err_count++;
    endtask

    task automatic gap_cycles();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
        repeat (g) @(posedge i_clk);
    endtask

    // Offer one element and hold it until the block takes it.
    task automatic send_element(input logic [63:0] re, input logic [63:0] im,
                                input logic first);
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap_cycles();
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_element(re, im, first);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MATRIX_SIZE: cfg_size   = value[10:0];
            REG_UPPER_MODE:  cfg_upper  = value[0];
            REG_DEST_STRIDE: cfg_stride = value[10:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Let outstanding results drain, plus a little margin for the stage.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input int n, input bit up, input int stride);
        drain();
        write_register(REG_MATRIX_SIZE, n);
        write_register(REG_UPPER_MODE, 32'(up));
        write_register(REG_DEST_STRIDE, stride);
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: d[62:52] = 11'h7FF;
            1: d[62:52] = 11'd0;
            2: d[62:52] = 11'($urandom_range(860, 900));
            3: d[62:52] = 11'($urandom_range(1140, 1160));
            default: d[62:52] = 11'($urandom_range(897, 1150));
        endcase
        return d;
    endfunction

    // Value edges: zeros, subnormals, rounding ties, FLT_MAX borders, NaN.
    task automatic test_directed_values();
        logic [63:0] v[$];
        configure(3, 1'b1, 5);
        v = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
              64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
              64'h47EF_FFFF_E000_0000, 64'h47EF_FFFF_F000_0000,
              64'h380F_FFFF_F000_0000, 64'h3690_0000_0000_0000,
              64'h3680_0000_0000_0001, 64'hFFF8_0000_0000_0001,
              64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
        foreach (v[i]) send_element(v[i], ~v[i], i == 0);
        // Infinity aborts; keep going past the end to see the wrap.
        send_element(64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b1);
        repeat (7) send_element(64'h4000_0000_0000_0000, 64'h0, 1'b0);
    endtask

    // Empty, single, largest and oversized matrices in both triangles.
    task automatic test_size_extremes();
        configure(0, 1'b0, 1);
        send_element(64'h7FF0_0000_0000_0000, 64'h0, 1'b1);
        send_element(64'h3FF0_0000_0000_0000, 64'h0, 1'b0);
        configure(1, 1'b0, 1024);
        repeat (3) send_element(rand_double(), rand_double(), 1'b0);
        configure(2047, 1'b1, 1024);
        send_element(64'h0, 64'h0, 1'b1);
        repeat (3) send_element(64'h3FF0_0000_0000_0000, 64'h0, 1'b0);
    endtask

    // Receiver holds off long enough for the block to fill and stall.
    task automatic test_backpressure();
        configure(4, 1'b0, 7);
        rx_hold = 1'b1;
        fork
            begin
                repeat (40) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (12) send_element(rand_double(), rand_double(), 1'b0);
        join
    endtask

    // Mostly whole matrices with random content, some stray first flags.
    task automatic test_random_matrices();
        int n;
        int total;
        int cnt;
        bit up;
        total = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        while (total < 1500) begin
            n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) % 40
                                             : $urandom_range(1, 12);
            up = $urandom_range(0, 1);
            configure(n, up, $urandom_range(0, 3) == 0 ? 1024 : $urandom_range(1, 60));
            cnt = (n * (n + 1)) / 2 + $urandom_range(0, 3);
            if (n == 0) cnt = 4;
            for (int k = 0; k < cnt; k++) begin
                send_element(($urandom_range(0, 30) == 0) ? 64'h7FF0_0000_0000_0000
                                                          : rand_double(),
                             rand_double(),
                             (k == 0) || ($urandom_range(0, 60) == 0));
                // Change the stride mid-matrix is not allowed while busy; skip.
            end
            // Occasionally reconfigure and let a walk continue across.
            if ($urandom_range(0, 4) == 0) begin
                drain();
                write_register(REG_DEST_STRIDE, $urandom_range(1, 1024));
                for (int k = 0; k < 5; k++) send_element(rand_double(), rand_double(), 1'b0);
            end
            total += cnt;
        end
        rx_gaps = 1'b0;
        tx_gaps = 1'b0;
    endtask

    // Receiver: random stalls, and the long hold when asked.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (rx_gaps && $urandom_range(0, 3) == 0)
                m_axis_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 : 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_elem_res w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result %0d", res_count);
                err_count++;
            end else begin
                w = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== w.sre)
                    report_mismatch("single_real", m_axis_tdata[31:0], w.sre);
                if (m_axis_tdata[63:32] !== w.sim)
                    report_mismatch("single_imag", m_axis_tdata[63:32], w.sim);
                if (m_axis_tdata[73:64] !== w.row)
                    report_mismatch("row", 32'(m_axis_tdata[73:64]), 32'(w.row));
                if (m_axis_tdata[83:74] !== w.col)
                    report_mismatch("col", 32'(m_axis_tdata[83:74]), 32'(w.col));
                if (m_axis_tdata[103:84] !== w.ofs)
                    report_mismatch("offset", 32'(m_axis_tdata[103:84]), 32'(w.ofs));
                if (m_axis_tdata[104] !== w.st_en)
                    report_mismatch("store_enable", 32'(m_axis_tdata[104]), 32'(w.st_en));
                if (m_axis_tdata[105] !== w.ovf)
                    report_mismatch("overflow", 32'(m_axis_tdata[105]), 32'(w.ovf));
                if (m_axis_tlast !== w.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(w.last));
            end
            res_count++;
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_triangular_double_to_single_convert: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_cycles   = 0;
        err_count     = 0;
        res_count     = 0;
        rx_gaps       = 1'b0;
        rx_hold       = 1'b0;
        tx_gaps       = 1'b0;
        cfg_size      = 0;
        cfg_upper     = 1'b1;
        cfg_stride    = 1;
        walk_row      = 0;
        walk_col      = 0;
        walk_base     = 0;
        walk_abort    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_values();
        test_size_extremes();
        test_backpressure();
        test_random_matrices();
        drain();
        $display("covered %0d results over edge values, size extremes, both triangles,",
                 res_count);
        $display("overflow aborts, wrap past the end and a long output stall");
        if (err_count == 0)
            $display("tb_triangular_double_to_single_convert: clean");
        else
            $display("tb_triangular_double_to_single_convert: errors");
        $finish;
    end
endmodule
